// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define AFL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same, with the consequent checked in the cycle after the antecedent.
`define AFL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) ante |=> cons) else $error(msg);

`endif

// ===== design/afl_pkg.sv =====
`default_nettype none
package afl_pkg;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_ALLOC  = 2'd1;
  localparam logic [1:0] KIND_CHECK  = 2'd2;
  localparam logic [1:0] KIND_REMOVE = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_NONE  = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] len;
  } entry_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] addr;
    logic [31:0] len;
    logic        is_free;
    logic [5:0]  count;
  } result_t;

endpackage
`default_nettype wire

// ===== design/afl_mem.sv =====
`default_nettype none
module afl_mem import afl_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  wire entry_t                     wr_data,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
  output entry_t                          rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== design/afl_ctrl.sv =====
`default_nettype none
module afl_ctrl import afl_pkg::*; #(
  parameter int MAX_BLOCKS   = 32,
  parameter int HEADER_BYTES = 12
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_kind,
  input  wire logic [31:0] in_addr,
  input  wire logic [31:0] in_len,
  input  wire logic [31:0] in_req,
  output logic             res_valid,
  input  wire logic        res_take,
  output result_t          res
);

  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);
  localparam logic [31:0] HDR = 32'(HEADER_BYTES);
  localparam logic [33:0] HDR34 = 34'(HEADER_BYTES);
  localparam logic [33:0] LIM34 = 34'h0_FFFF_FFFF;

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_FIN} state_t;

  state_t        state_r, state_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [31:0]   a_r, a_nxt, l_r, l_nxt, req_r, req_nxt;
  logic [CW-1:0] k_r, k_nxt, w_r, w_nxt, cnt_r, cnt_nxt;
  entry_t        cur_r, cur_nxt, carry_r, carry_nxt;
  logic          have_r, have_nxt, flag_r, flag_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [31:0]   raddr_r, raddr_nxt, rlen_r, rlen_nxt;
  logic          isfree_r, isfree_nxt;

  logic          wr_en;
  logic [IW-1:0] wr_addr, rd_addr;
  entry_t        wr_data, d;
  entry_t        c;
  logic          dv, merge_ok;
  logic [CW-1:0] kp1, km1;
  logic [31:0]   rest;

  afl_mem #(.DEPTH(MAX_BLOCKS)) u_mem (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(d)
  );

  assign dv   = k_r < cnt_r;
  assign kp1  = k_r + CW'(1);
  assign km1  = k_r - CW'(1);
  assign rest = cur_r.len - req_r;
  assign merge_ok = ({2'b0, cur_r.addr} + {2'b0, cur_r.len} + HDR34 == {2'b0, d.addr})
                 && ({2'b0, cur_r.len} + {2'b0, d.len} + HDR34 <= LIM34);

  always_comb begin
    state_nxt = state_r;  op_nxt = op_r;  a_nxt = a_r;  l_nxt = l_r;  req_nxt = req_r;
    k_nxt = k_r;  w_nxt = w_r;  cnt_nxt = cnt_r;  cur_nxt = cur_r;  carry_nxt = carry_r;
    have_nxt = have_r;  flag_nxt = flag_r;  status_nxt = status_r;
    raddr_nxt = raddr_r;  rlen_nxt = rlen_r;  isfree_nxt = isfree_r;
    wr_en = 1'b0;  wr_addr = k_r[IW-1:0];  wr_data = cur_r;  rd_addr = '0;  c = d;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt = in_kind;  a_nxt = in_addr;  l_nxt = in_len;  req_nxt = in_req;
          k_nxt = '0;  w_nxt = '0;  have_nxt = 1'b0;  flag_nxt = 1'b0;
          status_nxt = STAT_OK;  raddr_nxt = '0;  rlen_nxt = '0;  isfree_nxt = 1'b0;
          if (in_kind == KIND_INSERT && cnt_r >= MAXC) begin
            status_nxt = STAT_FULL;
            state_nxt  = S_FIN;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        rd_addr = kp1[IW-1:0];
        k_nxt   = kp1;
        case (op_r)
          KIND_INSERT: begin
            if (!flag_r) begin
              if (!dv || d.addr > a_r) begin
                wr_en = 1'b1;  wr_data = '{addr: a_r, len: l_r};
                carry_nxt = d;  flag_nxt = 1'b1;
              end
            end else begin
              wr_en = 1'b1;  wr_data = carry_r;  carry_nxt = d;
            end
            if (!dv) begin
              cnt_nxt = cnt_r + CW'(1);
              state_nxt = S_FIN;
            end
          end
          KIND_REMOVE: begin
            if (!dv) begin
              if (flag_r) cnt_nxt = cnt_r - CW'(1);
              else status_nxt = STAT_NONE;
              state_nxt = S_FIN;
            end else if (flag_r) begin
              wr_en = 1'b1;  wr_addr = km1[IW-1:0];  wr_data = d;
            end else if (d.addr == a_r) begin
              flag_nxt = 1'b1;
            end
          end
          KIND_CHECK: begin
            if (!dv) begin
              isfree_nxt = flag_r;
              state_nxt = S_FIN;
            end else if (d.addr == a_r) begin
              flag_nxt = 1'b1;
            end
          end
          KIND_ALLOC: begin
            if (!dv) begin
              if (!flag_r) begin
                if (have_r) begin
                  wr_en = 1'b1;  wr_addr = w_r[IW-1:0];  wr_data = cur_r;
                end
                cnt_nxt = w_r + CW'(have_r);
                status_nxt = STAT_NONE;
                state_nxt = S_FIN;
              end else begin
                cnt_nxt = w_r;
                raddr_nxt = cur_r.addr;
                if (rest > HDR) begin
                  rlen_nxt = req_r;
                  op_nxt = KIND_INSERT;
                  a_nxt = cur_r.addr + HDR + req_r;
                  l_nxt = rest - HDR;
                  flag_nxt = 1'b0;
                  k_nxt = '0;
                  rd_addr = '0;
                end else begin
                  rlen_nxt = cur_r.len;
                  state_nxt = S_FIN;
                end
              end
            end else if (!flag_r) begin
              if (have_r && merge_ok) begin
                c = '{addr: cur_r.addr, len: cur_r.len + d.len + HDR};
              end else if (have_r) begin
                wr_en = 1'b1;  wr_addr = w_r[IW-1:0];  wr_data = cur_r;
                w_nxt = w_r + CW'(1);
              end
              cur_nxt = c;
              have_nxt = 1'b1;
              if (c.len >= req_r) flag_nxt = 1'b1;
            end else begin
              wr_en = 1'b1;  wr_addr = w_r[IW-1:0];  wr_data = d;
              w_nxt = w_r + CW'(1);
            end
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_FIN: begin
        if (res_take) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    op_r <= op_nxt;  a_r <= a_nxt;  l_r <= l_nxt;  req_r <= req_nxt;
    k_r <= k_nxt;  w_r <= w_nxt;  cur_r <= cur_nxt;  carry_r <= carry_nxt;
    have_r <= have_nxt;  flag_r <= flag_nxt;  status_r <= status_nxt;
    raddr_r <= raddr_nxt;  rlen_r <= rlen_nxt;  isfree_r <= isfree_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_FIN);
  assign res = '{status: status_r, addr: raddr_r, len: rlen_r,
                 is_free: isfree_r, count: 6'(cnt_r)};

endmodule
`default_nettype wire

// ===== design/address_ordered_free_list_allocator.sv =====
// Address-ordered free block table with first-fit allocate and coalescing of
// contiguous neighbors. One request is handled at a time. Each request walks the
// table memory one entry per cycle, over every entry held at the start plus one,
// then hands its result to the output register. An allocate that splits its
// block walks the table a second time to put the leftover back. A full insert
// skips the walk and goes straight to its result. The next request is taken in
// the cycle after the result is handed over, while that result may still wait
// in the output register.
`default_nettype none
`include "assert_macros.svh"
module address_ordered_free_list_allocator import afl_pkg::*; #(
  parameter int MAX_BLOCKS   = 32,
  parameter int HEADER_BYTES = 12
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_kind,
  input  wire logic [31:0] in_block_addr,
  input  wire logic [31:0] in_block_length,
  input  wire logic [31:0] in_required_length,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [31:0]      out_result_addr,
  output logic [31:0]      out_result_length,
  output logic             out_is_free,
  output logic [5:0]       out_free_count
);

  logic    res_valid, res_take, out_valid_r;
  result_t res, out_r;

  afl_ctrl #(.MAX_BLOCKS(MAX_BLOCKS), .HEADER_BYTES(HEADER_BYTES)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_addr(in_block_addr), .in_len(in_block_length), .in_req(in_required_length),
    .res_valid(res_valid), .res_take(res_take), .res(res)
  );

  assign res_take = res_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (res_take) out_r <= res;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_r.status;
  assign out_result_addr   = out_r.addr;
  assign out_result_length = out_r.len;
  assign out_is_free       = out_r.is_free;
  assign out_free_count    = out_r.count;

  `AFL_ASSERT(a_full_count, clk, rst_n, out_valid && out_status == STAT_FULL |-> out_free_count == 6'(MAX_BLOCKS), "full status with short count")
  `AFL_ASSERT(a_fail_zero, clk, rst_n, out_valid && out_status != STAT_OK |-> out_result_addr == '0 && out_result_length == '0, "grant fields set on failure")
  `AFL_ASSERT_NEXT(a_one_busy, clk, rst_n, in_valid && in_ready, !in_ready, "second transfer taken while busy")

endmodule
`default_nettype wire
